@@ src/source_text_tokenizer_unit_assert.svh @@
// Assertion macros for the source text tokeniser.
// Depends on nothing; included by the checker module.
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define STT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define STT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/stt_pkg.sv @@
// Shared constants and types for the source text tokeniser.
// Depends on nothing; used by every module of the block.
`default_nettype none

package stt_pkg;

  localparam int KIND_W      = 5;
  localparam int PREFIX_W    = 48;
  localparam int QUEUE_DEPTH = 8;

  localparam logic [KIND_W-1:0] KIND_END    = 5'd0;
  localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd1;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 5'd2;
  localparam logic [KIND_W-1:0] KIND_FN     = 5'd3;
  localparam logic [KIND_W-1:0] KIND_LET    = 5'd4;
  localparam logic [KIND_W-1:0] KIND_RETURN = 5'd5;
  localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd6;
  localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd7;
  localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd8;
  localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd9;
  localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd10;
  localparam logic [KIND_W-1:0] KIND_COLON  = 5'd11;
  localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd12;
  localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd13;
  localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd14;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd15;
  localparam logic [KIND_W-1:0] KIND_ARROW  = 5'd16;

  localparam logic [PREFIX_W-1:0] KW_FN     = 48'h0000_0000_666E;
  localparam logic [PREFIX_W-1:0] KW_LET    = 48'h0000_006C_6574;
  localparam logic [PREFIX_W-1:0] KW_RETURN = 48'h7265_7475_726E;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;

  typedef struct packed {
    logic first;
    logic second;
  } tok_push_t;

endpackage

`default_nettype wire

@@ src/stt_front.sv @@
// Scanner front end: classifies each byte, tracks position and emits up to two tokens.
// Depends on stt_pkg.
`default_nettype none

module stt_front #(
  parameter int POSITION_WIDTH = 16,
  parameter int TOK_W = stt_pkg::KIND_W + 4 * POSITION_WIDTH + 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire logic [7:0]           char_in,
  output stt_pkg::tok_push_t        push_o,
  output logic      [TOK_W-1:0]     tok0_o,
  output logic      [TOK_W-1:0]     tok1_o
);

  localparam int PW = POSITION_WIDTH;
  localparam int KW = stt_pkg::KIND_W;
  localparam int XW = stt_pkg::PREFIX_W;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_MINUS   = 3'd3;
  localparam logic [2:0] MODE_SLASH   = 3'd4;
  localparam logic [2:0] MODE_COMMENT = 3'd5;
  localparam logic [2:0] MODE_HALTED  = 3'd6;

  localparam logic [PW-1:0] POS_ONE = PW'(1);
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

  logic [2:0]    mode_r, mode_nxt;
  logic [PW-1:0] off_r, off_nxt;
  logic [PW-1:0] line_r, line_nxt;
  logic [PW-1:0] col_r, col_nxt;
  logic [PW-1:0] tso_r, tso_nxt;
  logic [PW-1:0] tline_r, tline_nxt;
  logic [PW-1:0] tcol_r, tcol_nxt;
  logic [PW-1:0] tlen_r, tlen_nxt;
  logic [XW-1:0] prefix_r, prefix_nxt;

  logic          is_alpha, is_digit, is_ws;
  logic [KW-1:0] punct_kind;
  logic [KW-1:0] ident_kind;

  logic          id_emit, id_adv, id_mark, id_clear;
  logic [KW-1:0] id_kind;
  logic [PW-1:0] id_len;
  logic [2:0]    id_mode;

  logic          run_idle, pend_emit, m_adv, m_clear, m_grow;
  logic [KW-1:0] pend_kind;
  logic [PW-1:0] pend_len;
  logic [2:0]    m_mode;
  logic          emit_idle;

  always_comb begin
    is_alpha = (char_in >= 8'h61 && char_in <= 8'h7A) || (char_in >= 8'h41 && char_in <= 8'h5A)
               || char_in == stt_pkg::CH_UNDER;
    is_digit = char_in >= 8'h30 && char_in <= 8'h39;
    is_ws    = char_in == stt_pkg::CH_SPACE || char_in == stt_pkg::CH_TAB
               || char_in == stt_pkg::CH_CR || char_in == stt_pkg::CH_LF;
    unique case (char_in)
      8'h28:   punct_kind = stt_pkg::KIND_LPAREN;
      8'h29:   punct_kind = stt_pkg::KIND_RPAREN;
      8'h7B:   punct_kind = stt_pkg::KIND_LBRACE;
      8'h7D:   punct_kind = stt_pkg::KIND_RBRACE;
      8'h3B:   punct_kind = stt_pkg::KIND_SEMI;
      8'h3A:   punct_kind = stt_pkg::KIND_COLON;
      8'h2C:   punct_kind = stt_pkg::KIND_COMMA;
      8'h2B:   punct_kind = stt_pkg::KIND_PLUS;
      8'h3D:   punct_kind = stt_pkg::KIND_ASSIGN;
      default: punct_kind = stt_pkg::KIND_END;
    endcase
    priority if (tlen_r == PW'(2) && prefix_r == stt_pkg::KW_FN) begin
      ident_kind = stt_pkg::KIND_FN;
    end else if (tlen_r == PW'(3) && prefix_r == stt_pkg::KW_LET) begin
      ident_kind = stt_pkg::KIND_LET;
    end else if (tlen_r == PW'(6) && prefix_r == stt_pkg::KW_RETURN) begin
      ident_kind = stt_pkg::KIND_RETURN;
    end else begin
      ident_kind = stt_pkg::KIND_IDENT;
    end
  end

  // Scan from the idle mode at the current position.
  always_comb begin
    id_emit  = 1'b0;
    id_adv   = 1'b0;
    id_mark  = 1'b0;
    id_clear = 1'b0;
    id_kind  = stt_pkg::KIND_END;
    id_len   = '0;
    id_mode  = MODE_IDLE;
    priority if (char_in == stt_pkg::CH_NUL) begin
      id_emit  = 1'b1;
      id_clear = 1'b1;
    end else if (is_ws) begin
      id_adv = 1'b1;
    end else if (is_alpha) begin
      id_mark = 1'b1;
      id_adv  = 1'b1;
      id_mode = MODE_IDENT;
    end else if (is_digit) begin
      id_mark = 1'b1;
      id_adv  = 1'b1;
      id_mode = MODE_NUMBER;
    end else if (char_in == stt_pkg::CH_MINUS) begin
      id_mark = 1'b1;
      id_adv  = 1'b1;
      id_mode = MODE_MINUS;
    end else if (char_in == stt_pkg::CH_SLASH) begin
      id_mark = 1'b1;
      id_adv  = 1'b1;
      id_mode = MODE_SLASH;
    end else if (punct_kind != stt_pkg::KIND_END) begin
      id_emit = 1'b1;
      id_adv  = 1'b1;
      id_kind = punct_kind;
      id_len  = POS_ONE;
    end else begin
      id_emit = 1'b1;
      id_mode = MODE_HALTED;
    end
  end

  always_comb begin
    run_idle  = 1'b0;
    pend_emit = 1'b0;
    pend_kind = stt_pkg::KIND_END;
    pend_len  = tlen_r;
    m_adv     = 1'b0;
    m_clear   = 1'b0;
    m_grow    = 1'b0;
    m_mode    = mode_r;
    unique case (mode_r)
      MODE_IDENT, MODE_NUMBER: begin
        if ((mode_r == MODE_IDENT) ? (is_alpha || is_digit) : is_digit) begin
          m_grow = 1'b1;
          m_adv  = 1'b1;
        end else begin
          pend_emit = 1'b1;
          pend_kind = (mode_r == MODE_IDENT) ? ident_kind : stt_pkg::KIND_NUMBER;
          run_idle  = 1'b1;
        end
      end
      MODE_MINUS: begin
        pend_emit = 1'b1;
        if (char_in == stt_pkg::CH_GT) begin
          pend_kind = stt_pkg::KIND_ARROW;
          pend_len  = PW'(2);
          m_mode    = MODE_IDLE;
          m_adv     = 1'b1;
        end else begin
          pend_kind = stt_pkg::KIND_MINUS;
          run_idle  = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (char_in == stt_pkg::CH_SLASH) begin
          m_mode = MODE_COMMENT;
          m_adv  = 1'b1;
        end else begin
          pend_emit = 1'b1;
          pend_len  = '0;
          m_clear   = char_in == stt_pkg::CH_NUL;
          m_mode    = MODE_HALTED;
        end
      end
      MODE_COMMENT: begin
        if (char_in == stt_pkg::CH_NUL) begin
          run_idle = 1'b1;
        end else begin
          m_adv = 1'b1;
          if (char_in == stt_pkg::CH_LF) begin
            m_mode = MODE_IDLE;
          end
        end
      end
      MODE_HALTED: begin
        m_clear = char_in == stt_pkg::CH_NUL;
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase
  end

  always_comb begin
    mode_nxt   = run_idle ? id_mode : m_mode;
    off_nxt    = off_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    tso_nxt    = tso_r;
    tline_nxt  = tline_r;
    tcol_nxt   = tcol_r;
    tlen_nxt   = tlen_r;
    prefix_nxt = prefix_r;
    if (run_idle && id_mark) begin
      tso_nxt    = off_r;
      tline_nxt  = line_r;
      tcol_nxt   = col_r;
      tlen_nxt   = POS_ONE;
      prefix_nxt = XW'(char_in);
    end
    if (!run_idle && m_grow) begin
      tlen_nxt = (tlen_r == POS_MAX) ? tlen_r : tlen_r + POS_ONE;
      if (mode_r == MODE_IDENT && tlen_r < PW'(6)) begin
        prefix_nxt = {prefix_r[XW-9:0], char_in};
      end
    end
    if (run_idle ? id_adv : m_adv) begin
      off_nxt = off_r + POS_ONE;
      if (char_in == stt_pkg::CH_LF) begin
        line_nxt = (line_r == POS_MAX) ? line_r : line_r + POS_ONE;
        col_nxt  = POS_ONE;
      end else begin
        col_nxt = (col_r == POS_MAX) ? col_r : col_r + POS_ONE;
      end
    end
    if (run_idle ? id_clear : m_clear) begin
      mode_nxt   = MODE_IDLE;
      off_nxt    = '0;
      line_nxt   = POS_ONE;
      col_nxt    = POS_ONE;
      tso_nxt    = '0;
      tline_nxt  = POS_ONE;
      tcol_nxt   = POS_ONE;
      tlen_nxt   = '0;
      prefix_nxt = '0;
    end
  end

  always_comb begin
    emit_idle     = run_idle && id_emit;
    push_o.first  = accept && (pend_emit || emit_idle);
    push_o.second = accept && pend_emit && emit_idle;
    tok1_o        = {id_kind, off_r, id_len, line_r, col_r, 1'b1};
    tok0_o        = pend_emit ? {pend_kind, tso_r, pend_len, tline_r, tcol_r, !emit_idle}
                              : tok1_o;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      off_r    <= '0;
      line_r   <= POS_ONE;
      col_r    <= POS_ONE;
      tso_r    <= '0;
      tline_r  <= POS_ONE;
      tcol_r   <= POS_ONE;
      tlen_r   <= '0;
      prefix_r <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      off_r    <= off_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      tso_r    <= tso_nxt;
      tline_r  <= tline_nxt;
      tcol_r   <= tcol_nxt;
      tlen_r   <= tlen_nxt;
      prefix_r <= prefix_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/stt_queue.sv @@
// Token queue between the scanner and the result port: two writes, one read per cycle.
// Depends on stt_pkg.
`default_nettype none

module stt_queue #(
  parameter int DATA_W = 70
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire stt_pkg::tok_push_t push_i,
  input  wire logic  [DATA_W-1:0] wdata0_i,
  input  wire logic  [DATA_W-1:0] wdata1_i,
  input  wire logic               pop_i,
  output logic                    full_o,
  output logic                    empty_o,
  output logic       [DATA_W-1:0] rdata_o
);

  localparam int DEPTH = stt_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_pop;

  always_comb begin
    empty_o    = count_r == '0;
    full_o     = count_r > CNT_W'(DEPTH - 2);
    rdata_o    = mem[rd_ptr_r];
    do_pop     = pop_i && !empty_o;
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_i.first) + PTR_W'(push_i.second);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(do_pop);
    count_nxt  = count_r + CNT_W'(push_i.first) + CNT_W'(push_i.second) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push_i.first) begin
      mem[wr_ptr_r] <= wdata0_i;
    end
    if (push_i.second) begin
      mem[wr_ptr_r + PTR_W'(1)] <= wdata1_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/source_text_tokenizer_unit.sv @@
// A token is readable in the cycle after the byte that closes it is accepted.
// One byte per cycle unless full; each yields up to two tokens into an eight-entry queue.
// full rises at seven queued tokens, so bytes stall only while results go untaken.
// Reset (synchronous, active low) empties the queue and sets line and column to 1.
// A zero byte ends the source and returns the scanner to its reset state.
`default_nettype none

module source_text_tokenizer_unit #(
  parameter int POSITION_WIDTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [7:0]                in_char_in,
  output logic                           empty,
  input  wire logic                      pop,
  output logic [stt_pkg::KIND_W-1:0]     out_kind,
  output logic [POSITION_WIDTH-1:0]      out_start_offset,
  output logic [POSITION_WIDTH-1:0]      out_length,
  output logic [POSITION_WIDTH-1:0]      out_line,
  output logic [POSITION_WIDTH-1:0]      out_column,
  output logic                           out_last_of_run
);

  localparam int TOK_W = stt_pkg::KIND_W + 4 * POSITION_WIDTH + 1;

  stt_pkg::tok_push_t tok_push;
  logic [TOK_W-1:0]   tok0;
  logic [TOK_W-1:0]   tok1;
  logic [TOK_W-1:0]   head;
  logic               accept;

  assign accept = push && !full;

  stt_front #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .TOK_W          (TOK_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .char_in (in_char_in),
    .push_o  (tok_push),
    .tok0_o  (tok0),
    .tok1_o  (tok1)
  );

  stt_queue #(
    .DATA_W (TOK_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (tok_push),
    .wdata0_i (tok0),
    .wdata1_i (tok1),
    .pop_i    (pop),
    .full_o   (full),
    .empty_o  (empty),
    .rdata_o  (head)
  );

  assign {out_kind, out_start_offset, out_length, out_line, out_column, out_last_of_run} = head;

endmodule

`default_nettype wire

@@ src/stt_checker.sv @@
// Port-level checks for the source text tokeniser, bound to the top level.
// Depends on stt_pkg and source_text_tokenizer_unit_assert.svh.
`default_nettype none

`include "source_text_tokenizer_unit_assert.svh"

module stt_checker #(
  parameter int POSITION_WIDTH = 16
) (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      push,
  input wire logic                      full,
  input wire logic                      empty,
  input wire logic                      pop,
  input wire logic [stt_pkg::KIND_W-1:0] out_kind,
  input wire logic [POSITION_WIDTH-1:0] out_start_offset,
  input wire logic [POSITION_WIDTH-1:0] out_length,
  input wire logic [POSITION_WIDTH-1:0] out_line,
  input wire logic [POSITION_WIDTH-1:0] out_column,
  input wire logic                      out_last_of_run
);

  logic held;
  logic byte_seen;
  logic [stt_pkg::KIND_W+4*POSITION_WIDTH:0] head_view;

  assign held      = !empty && !pop;
  assign byte_seen = push && !full;
  assign head_view = {out_kind, out_start_offset, out_length, out_line, out_column,
                      out_last_of_run};

  `STT_ASSERT_NXT(a_head_held, clk, rst_n, held, (!empty && $stable(head_view)), "result changed while waiting")
  `STT_ASSERT_IMP(a_kind_range, clk, rst_n, !empty, (out_kind <= stt_pkg::KIND_ARROW), "token kind out of range")
  `STT_ASSERT_IMP(a_pos_nonzero, clk, rst_n, !empty, (out_line != '0 && out_column != '0), "line or column is zero")
  `STT_ASSERT_IMP(a_end_last, clk, rst_n, (!empty && out_kind == stt_pkg::KIND_END), (out_length == '0 && out_last_of_run), "end token not last or has length")
  `STT_ASSERT_NXT(a_idle_quiet, clk, rst_n, (empty && !byte_seen), empty, "result with no byte taken")

endmodule

bind source_text_tokenizer_unit stt_checker #(
  .POSITION_WIDTH (POSITION_WIDTH)
) u_stt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .push             (push),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .out_kind         (out_kind),
  .out_start_offset (out_start_offset),
  .out_length       (out_length),
  .out_line         (out_line),
  .out_column       (out_column),
  .out_last_of_run  (out_last_of_run)
);

`default_nettype wire
